>>> rtl/core/shortest_queue_dispatcher_core_assert.svh
// Assertion macros for the shortest queue dispatcher core.
// Define NO_ASSERTIONS to compile them out.
`ifndef SHORTEST_QUEUE_DISPATCHER_CORE_ASSERT_SVH
`define SHORTEST_QUEUE_DISPATCHER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SQD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SQD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SQD_ASSERT(label, clk, rstn, prop, msg)
`define SQD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/sqd_pkg.sv
// Shared types and constants of the shortest queue dispatcher.
// No dependencies.
package sqd_pkg;
    localparam int SQD_NUM_SERVERS = 8;
    localparam int SQD_QUEUE_DEPTH = 16;
    localparam logic [1:0] KIND_ASSIGNED  = 2'd0;
    localparam logic [1:0] KIND_COMPLETED = 2'd1;
    localparam logic [1:0] KIND_REJECTED  = 2'd2;
    localparam logic       ACT_ARRIVAL    = 1'b0;
    localparam logic       ACT_TICK       = 1'b1;

    // Command handed from the sequencer to one cell.
    typedef struct packed {
        logic arrive;   // append the held client at the tail
        logic tick;     // run one tick on this server
    } sqd_cmd_t;

    // Report from a cell back to the sequencer.
    typedef struct packed {
        logic        done;
        logic        completed;
        logic [15:0] client;
        logic [31:0] wait_ticks;
    } sqd_rpt_t;
endpackage

>>> rtl/core/shortest_queue_dispatcher_core.sv
// Join-shortest-queue dispatcher: a row of server cells (sqd_cell, sqd_pkg, assert macros).
// Arrival, n enabled servers: scan one cell a cycle, load the result in S_ARR, then take the
// next beat in S_IDLE. Tick: per enabled server, an empty cell reports without a read, else it
// reads and decrements its head and, on a completion with a new head left, decrements that
// too; S_END closes. A busy output register stalls arrivals and the tick sequencer. Reset
// (aresetn low, sync) empties all queues, clears time and sets num_servers to 8.
`include "shortest_queue_dispatcher_core_assert.svh"
module shortest_queue_dispatcher_core import sqd_pkg::*; #(
    parameter int NUM_SERVERS = SQD_NUM_SERVERS,
    parameter int QUEUE_DEPTH = SQD_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // client_id[15:0], svc_ticks[23:16]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // server[2:0], client_out[18:3], wait_ticks[50:19], zeros
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int NW = $clog2(NUM_SERVERS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ARR, S_TICK, S_WAIT, S_END} state_t;

    state_t      state_reg;
    logic [3:0]  nsrv_reg;
    logic [31:0] now_reg;
    logic [15:0] client_reg;
    logic [7:0]  svc_reg;
    logic [SW-1:0] idx_reg;
    logic [SW-1:0] best_reg;
    logic [CW-1:0] best_cnt_reg;
    logic        pend_valid_reg;
    logic [SW-1:0] pend_srv_reg;
    logic [15:0] pend_cl_reg;
    logic [31:0] pend_wait_reg;
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [2:0]  m_srv_reg;
    logic [15:0] m_cl_reg;
    logic [31:0] m_wait_reg;
    logic        m_last_reg;

    logic [NW-1:0] n_act;
    logic [CW-1:0] counts [NUM_SERVERS];
    sqd_rpt_t      rpts   [NUM_SERVERS];
    sqd_cmd_t      cmds   [NUM_SERVERS];
    sqd_rpt_t      rpt_cur;
    logic          idx_last;
    logic          out_free;
    logic          tick_go;
    logic          m_load;

    always_comb begin
        if (nsrv_reg == 4'd0) n_act = NW'(1);
        else if (32'(nsrv_reg) > NUM_SERVERS) n_act = NW'(NUM_SERVERS);
        else n_act = NW'(nsrv_reg);
    end
    assign idx_last = (NW'(idx_reg) + NW'(1) >= n_act);
    assign out_free = !m_valid_reg || m_tready;
    assign rpt_cur = rpts[idx_reg];
    // A held completion must be able to move out the moment the next one arrives.
    assign tick_go = !(pend_valid_reg && m_valid_reg);

    always_comb begin
        case (state_reg)
            S_ARR:   m_load = out_free;
            S_WAIT:  m_load = rpt_cur.done && rpt_cur.completed && pend_valid_reg;
            S_END:   m_load = pend_valid_reg && out_free;
            default: m_load = 1'b0;
        endcase
    end

    for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_cell
        assign cmds[g] = '{arrive: (state_reg == S_ARR) && out_free && (best_reg == SW'(g)),
                           tick: (state_reg == S_TICK) && tick_go && (idx_reg == SW'(g))};
        sqd_cell #(.QUEUE_DEPTH(QUEUE_DEPTH), .CW(CW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmds[g]),
            .client_in(client_reg), .service_in(svc_reg), .now(now_reg),
            .count(counts[g]), .rpt(rpts[g])
        );
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {5'd0, m_wait_reg, m_cl_reg, m_srv_reg};
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            nsrv_reg <= 4'd8;
            now_reg <= '0;
            m_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (cfg_we) nsrv_reg <= cfg_wdata;
            if (m_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        client_reg <= s_tdata[15:0];
                        svc_reg <= s_tdata[23:16];
                        idx_reg <= '0;
                        best_reg <= '0;
                        best_cnt_reg <= counts[0];
                        state_reg <= (s_tuser == ACT_TICK) ? S_TICK : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (counts[idx_reg] < best_cnt_reg) begin
                        best_reg <= idx_reg;
                        best_cnt_reg <= counts[idx_reg];
                    end
                    if (idx_last) state_reg <= S_ARR;
                    else idx_reg <= idx_reg + SW'(1);
                end
                S_ARR: begin
                    if (out_free) begin
                        m_kind_reg <= (best_cnt_reg >= CW'(QUEUE_DEPTH)) ?
                                      KIND_REJECTED : KIND_ASSIGNED;
                        m_srv_reg <= 3'(best_reg);
                        m_cl_reg <= client_reg;
                        m_wait_reg <= '0;
                        m_last_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_TICK: begin
                    if (tick_go) state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (rpt_cur.done) begin
                        if (rpt_cur.completed) begin
                            // Hold the newest completion back so the final one can carry tlast.
                            if (pend_valid_reg) begin
                                m_kind_reg <= KIND_COMPLETED;
                                m_srv_reg <= 3'(pend_srv_reg);
                                m_cl_reg <= pend_cl_reg;
                                m_wait_reg <= pend_wait_reg;
                                m_last_reg <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_srv_reg <= idx_reg;
                            pend_cl_reg <= rpt_cur.client;
                            pend_wait_reg <= rpt_cur.wait_ticks;
                        end
                        if (idx_last) begin
                            state_reg <= S_END;
                        end else begin
                            idx_reg <= idx_reg + SW'(1);
                            state_reg <= S_TICK;
                        end
                    end
                end
                S_END: begin
                    if (!pend_valid_reg) begin
                        now_reg <= now_reg + 32'd1;
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        m_kind_reg <= KIND_COMPLETED;
                        m_srv_reg <= 3'(pend_srv_reg);
                        m_cl_reg <= pend_cl_reg;
                        m_wait_reg <= pend_wait_reg;
                        m_last_reg <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        now_reg <= now_reg + 32'd1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SQD_ASSERT(a_ready_idle, aclk, aresetn, s_tready |-> !pend_valid_reg, "pending completion while idle")
    `SQD_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
    `SQD_ASSERT(a_held, aclk, aresetn, state_reg == S_WAIT && pend_valid_reg |-> !m_valid_reg, "output busy")
    `SQD_ASSERT_RST(a_reset, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule

>>> rtl/core/sqd_cell.sv
// One server cell: a ring queue in local memory plus head and count.
// Depends on sqd_pkg.
module sqd_cell import sqd_pkg::*; #(
    parameter int QUEUE_DEPTH = SQD_QUEUE_DEPTH,
    parameter int CW = $clog2(QUEUE_DEPTH + 1),
    parameter int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  sqd_cmd_t    cmd,
    input  logic [15:0] client_in,
    input  logic [7:0]  service_in,
    input  logic [31:0] now,
    output logic [CW-1:0] count,
    output sqd_rpt_t    rpt
);
    typedef enum logic [2:0] {C_IDLE, C_RD, C_CHK, C_RD2, C_WB2} cstate_t;

    logic [8:0]  mem_cd   [QUEUE_DEPTH];
    logic [15:0] mem_cl   [QUEUE_DEPTH];
    logic [7:0]  mem_sv   [QUEUE_DEPTH];
    logic [31:0] mem_ar   [QUEUE_DEPTH];

    cstate_t     state_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] rd_addr;
    logic [8:0]  rd_cd_reg;
    logic [15:0] rd_cl_reg;
    logic [7:0]  rd_sv_reg;
    logic [31:0] rd_ar_reg;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [8:0]  wr_cd;
    logic [AW-1:0] tail;
    logic [AW:0] tail_sum;
    logic [AW:0] head_inc;
    logic [8:0]  dec;
    sqd_rpt_t    rpt_reg;

    assign count = count_reg;
    assign rpt = rpt_reg;
    // An append only happens while the count is below the depth, so it fits the sum.
    assign tail_sum = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                  AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign head_inc = {1'b0, head_reg} + (AW+1)'(1);
    assign dec = rd_cd_reg - 9'd1;
    assign rd_addr = head_reg;

    // Memory: one write port, one registered read port at the head.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_cd[wr_addr] <= wr_cd;
            if (cmd.arrive) begin
                mem_cl[wr_addr] <= client_in;
                mem_sv[wr_addr] <= service_in;
                mem_ar[wr_addr] <= now;
            end
        end
        rd_cd_reg <= mem_cd[rd_addr];
        rd_cl_reg <= mem_cl[rd_addr];
        rd_sv_reg <= mem_sv[rd_addr];
        rd_ar_reg <= mem_ar[rd_addr];
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = head_reg;
        wr_cd = dec;
        if (state_reg == C_IDLE && cmd.arrive && count_reg < CW'(QUEUE_DEPTH)) begin
            wr_en = 1'b1;
            wr_addr = tail;
            wr_cd = {1'b0, service_in};
        end else if (state_reg == C_CHK && !dec[8]) begin
            wr_en = 1'b1;
        end else if (state_reg == C_WB2) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            rpt_reg <= '0;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (cmd.arrive && count_reg < CW'(QUEUE_DEPTH)) begin
                        count_reg <= count_reg + CW'(1);
                        rpt_reg.done <= 1'b0;
                    end else if (cmd.tick && count_reg == '0) begin
                        rpt_reg <= '{done: 1'b1, completed: 1'b0,
                                     client: 16'd0, wait_ticks: 32'd0};
                    end else begin
                        rpt_reg.done <= 1'b0;
                        if (cmd.tick) state_reg <= C_RD;
                    end
                end
                C_RD: begin
                    rpt_reg.done <= 1'b0;
                    state_reg <= C_CHK;
                end
                C_CHK: begin
                    if (!dec[8]) begin
                        rpt_reg <= '{done: 1'b1, completed: 1'b0,
                                     client: 16'd0, wait_ticks: 32'd0};
                        state_reg <= C_IDLE;
                    end else begin
                        // The report is done here unless a new head still needs its decrement.
                        rpt_reg <= '{done: (count_reg == CW'(1)), completed: 1'b1,
                                     client: rd_cl_reg,
                                     wait_ticks: now - 32'(rd_sv_reg) - rd_ar_reg};
                        head_reg <= (head_inc >= (AW+1)'(QUEUE_DEPTH)) ?
                                    '0 : AW'(head_inc);
                        count_reg <= count_reg - CW'(1);
                        state_reg <= (count_reg == CW'(1)) ? C_IDLE : C_RD2;
                    end
                end
                C_RD2: begin
                    rpt_reg.done <= 1'b0;
                    state_reg <= C_WB2;
                end
                C_WB2: begin
                    rpt_reg.done <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: begin
                    rpt_reg.done <= 1'b0;
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end
endmodule

>>> tb/tb_shortest_queue_dispatcher_core.sv
// Self-checking testbench for shortest_queue_dispatcher_core.
// Holds its own model of the server queues and checks every result beat in order.
// Depends on sqd_pkg and the dispatcher RTL only.
`timescale 1ns / 100ps
module tb_shortest_queue_dispatcher_core;
    import sqd_pkg::*;

    localparam int NSRV  = SQD_NUM_SERVERS;
    localparam int DEPTH = SQD_QUEUE_DEPTH;
    // Long enough for a tick to finish over every server.
    localparam int SETTLE_CYCLES = 6 * NSRV + 20;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  server;
        logic [15:0] client;
        logic [31:0] wait_ticks;
        logic        last;
    } dispatch_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // client_id[15:0], svc_ticks[23:16]
    logic        s_tuser = 1'b0; // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // server[2:0], client_out[18:3], wait_ticks[50:19], zeros
    logic [1:0]  m_tuser;        // kind
    logic        m_tlast;

    shortest_queue_dispatcher_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Queue model.
    logic signed [8:0] slot_countdown [NSRV*DEPTH];
    logic [15:0]       slot_client    [NSRV*DEPTH];
    logic [7:0]        slot_service   [NSRV*DEPTH];
    logic [31:0]       slot_arrival   [NSRV*DEPTH];
    int                q_head [NSRV];
    int                q_len  [NSRV];
    logic [31:0]       now_ticks = '0;
    logic [3:0]        servers_reg = 4'd8;

    dispatch_result_t  pending_results[$];
    int                error_count = 0;
    int                burst_left = 0;
    logic              hold_active = 1'b0;
    event              hold_go;

    function automatic int enabled_servers();
        if (servers_reg == 0) return 1;
        if (servers_reg > NSRV) return NSRV;
        return servers_reg;
    endfunction

    function automatic void predict_dispatch(logic action, logic [15:0] client,
                                             logic [7:0] svc);
        int n, best, idx, first;
        dispatch_result_t r;
        n = enabled_servers();
        if (action == ACT_ARRIVAL) begin
            best = 0;
            for (int s = 1; s < n; s++)
                if (q_len[s] < q_len[best]) best = s;
            r.server = best[2:0];
            r.client = client;
            r.wait_ticks = '0;
            r.last = 1'b1;
            if (q_len[best] >= DEPTH) begin
                r.kind = KIND_REJECTED;
            end else begin
                idx = best * DEPTH + (q_head[best] + q_len[best]) % DEPTH;
                slot_countdown[idx] = {1'b0, svc};
                slot_client[idx] = client;
                slot_service[idx] = svc;
                slot_arrival[idx] = now_ticks;
                q_len[best]++;
                r.kind = KIND_ASSIGNED;
            end
            pending_results.push_back(r);
        end else begin
            first = pending_results.size();
            for (int s = 0; s < n; s++) begin
                if (q_len[s] == 0) continue;
                idx = s * DEPTH + q_head[s];
                slot_countdown[idx] = slot_countdown[idx] - 9'sd1;
                if (slot_countdown[idx] < 0) begin
                    r.kind = KIND_COMPLETED;
                    r.server = s[2:0];
                    r.client = slot_client[idx];
                    r.wait_ticks = now_ticks - {24'd0, slot_service[idx]} - slot_arrival[idx];
                    r.last = 1'b0;
                    pending_results.push_back(r);
                    q_head[s] = (q_head[s] + 1) % DEPTH;
                    q_len[s]--;
                    if (q_len[s] > 0) begin
                        idx = s * DEPTH + q_head[s];
                        slot_countdown[idx] = slot_countdown[idx] - 9'sd1;
                    end
                end
            end
            if (pending_results.size() > first)
                pending_results[pending_results.size() - 1].last = 1'b1;
            now_ticks++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        dispatch_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, e.kind));
                if (m_tdata[2:0] !== e.server)
                    report_mismatch($sformatf("server %0d, expected %0d",
                                              m_tdata[2:0], e.server));
                if (m_tdata[18:3] !== e.client)
                    report_mismatch($sformatf("client %h, expected %h",
                                              m_tdata[18:3], e.client));
                if (m_tdata[50:19] !== e.wait_ticks)
                    report_mismatch($sformatf("wait %0d, expected %0d",
                                              m_tdata[50:19], e.wait_ticks));
                if (m_tdata[55:51] !== 5'd0)
                    report_mismatch("nonzero padding in result data");
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last %b, expected %b", m_tlast, e.last));
            end
        end
    end

    // Long receiver hold-off, counted here in cycles.
    always begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (400) @(posedge aclk);
        hold_active = 1'b0;
    end

    // Receiver: random stall runs and ready runs, with an optional long hold-off.
    always @(posedge aclk) begin
        if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_item(input logic action, input logic [15:0] client,
                             input logic [7:0] svc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= {svc, client};
        do @(posedge aclk); while (!s_tready);
        predict_dispatch(action, client, svc);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 16'($urandom), 8'($urandom));
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending_results.size() == 0);
        @(posedge aclk);
    endtask

    task automatic write_servers(input logic [3:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        servers_reg = value;
        @(posedge aclk);
    endtask

    task automatic test_field_extremes();
        send_item(ACT_ARRIVAL, 16'h0000, 8'd0);
        send_item(ACT_ARRIVAL, 16'hFFFF, 8'd255);
        send_item(ACT_ARRIVAL, 16'hA5A5, 8'd1);
        send_tick();
        send_tick();
        send_tick();
    endtask

    // One server: queue fills and rejects, zero-service heads complete back to back.
    task automatic test_single_server();
        write_servers(4'd1);
        send_item(ACT_ARRIVAL, 16'h1111, 8'd0);
        send_item(ACT_ARRIVAL, 16'h2222, 8'd0);
        send_tick();
        send_tick();
        send_tick();
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(ACT_ARRIVAL, 16'(16'h3000 + i), 8'd0);
        repeat (DEPTH + 2) send_tick();
    endtask

    // Zero acts as one, and fifteen acts as the full server count.
    task automatic test_register_range();
        write_servers(4'd0);
        send_item(ACT_ARRIVAL, 16'h4001, 8'd2);
        send_item(ACT_ARRIVAL, 16'h4002, 8'd2);
        write_servers(4'd15);
        for (int i = 0; i < 10; i++)
            send_item(ACT_ARRIVAL, 16'(16'h5000 + i), 8'd1);
        repeat (3) send_tick();
    endtask

    // Disabled queues keep their clients until they are enabled again.
    task automatic test_disabled_servers();
        write_servers(4'd8);
        repeat (8) send_item(ACT_ARRIVAL, 16'($urandom), 8'd3);
        write_servers(4'd3);
        repeat (6) send_tick();
        write_servers(4'd8);
        repeat (6) send_tick();
    endtask

    task automatic test_backpressure();
        write_servers(4'd5);
        -> hold_go;
        for (int i = 0; i < 30; i++)
            if (i % 3 == 2) send_tick();
            else send_item(ACT_ARRIVAL, 16'($urandom), 8'($urandom_range(0, 2)));
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [3:0] settings [5] = '{4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
        for (int p = 0; p < 5; p++) begin
            write_servers(settings[p]);
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 9) < 6)
                    send_tick();
                else if ($urandom_range(0, 19) == 0)
                    send_item(ACT_ARRIVAL, 16'($urandom), 8'($urandom));
                else
                    send_item(ACT_ARRIVAL, 16'($urandom), 8'($urandom_range(0, 6)));
            end
        end
        drain_results();
    endtask

    initial begin
        for (int s = 0; s < NSRV; s++) begin
            q_head[s] = 0;
            q_len[s] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_single_server();
        test_register_range();
        test_disabled_servers();
        test_backpressure();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
